### rtl/core/lsfc_pkg.sv
// ----------------------------------------------------------------------------
// lsfc_pkg
// Shared types, codes and constants of the lamp switch flash controller.
// ----------------------------------------------------------------------------
package lsfc_pkg;

  localparam int NUM_LAMPS = 4;
  localparam int LAMP_W    = $clog2(NUM_LAMPS);
  localparam int CNT_W     = 32;
  localparam int PER_W     = 16;

  // config register indexes
  localparam logic CFG_SEND_PERIOD  = 1'b0;
  localparam logic CFG_UPPER_SUPPLY = 1'b1;

  localparam logic [PER_W-1:0] SEND_PERIOD_RST  = 16'd100;
  localparam logic             UPPER_SUPPLY_RST = 1'b1;

  // counter wraps from this value back to zero
  localparam logic [CNT_W-1:0] TICK_LAST = 32'hFFFF_FFFD;

  // item kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // command codes
  localparam logic [3:0] CMD_BRAKE_OFF   = 4'd0;
  localparam logic [3:0] CMD_BRAKE_ON    = 4'd1;
  localparam logic [3:0] CMD_MOTOR_OFF   = 4'd2;
  localparam logic [3:0] CMD_MOTOR_ON    = 4'd3;
  localparam logic [3:0] CMD_HEAD_OFF    = 4'd4;
  localparam logic [3:0] CMD_HEAD_FLASH  = 4'd6;
  localparam logic [3:0] CMD_REAR_OFF    = 4'd7;
  localparam logic [3:0] CMD_REAR_FLASH  = 4'd9;
  localparam logic [3:0] CMD_LEFT_OFF    = 4'd10;
  localparam logic [3:0] CMD_LEFT_FLASH  = 4'd12;
  localparam logic [3:0] CMD_RIGHT_OFF   = 4'd13;
  localparam logic [3:0] CMD_RIGHT_FLASH = 4'd15;

  // lamp actions
  localparam logic [1:0] ACT_OFF   = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_FLASH = 2'd2;

  // lamp slots
  localparam logic [LAMP_W-1:0] LAMP_HEAD  = 2'd0;
  localparam logic [LAMP_W-1:0] LAMP_REAR  = 2'd1;
  localparam logic [LAMP_W-1:0] LAMP_LEFT  = 2'd2;
  localparam logic [LAMP_W-1:0] LAMP_RIGHT = 2'd3;

  // switch word field patterns
  localparam logic [15:0] SW_LEFT  = 16'h3000;
  localparam logic [15:0] SW_RIGHT = 16'h0C00;
  localparam logic [15:0] SW_BRAKE = 16'h000C;
  localparam logic [15:0] SW_HEAD  = 16'h0003;
  localparam logic [15:0] SW_UPPER = 16'h0030;

  // wide status codes; flashing lit is binary 11
  localparam logic [1:0] ST_OFF       = 2'b00;
  localparam logic [1:0] ST_ON        = 2'b01;
  localparam logic [1:0] ST_FLASH_LIT = 2'b11;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } mod_rsp_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamp;
    logic [1:0]        act;
  } cmd_dec_t;

  function automatic cmd_dec_t decode_cmd(input logic [3:0] cmd);
    cmd_dec_t d;
    d.lamp = LAMP_HEAD;
    d.act  = ACT_OFF;
    if (cmd inside {[CMD_HEAD_OFF:CMD_HEAD_FLASH]}) begin
      d.lamp = LAMP_HEAD;
      d.act  = 2'(cmd - CMD_HEAD_OFF);
    end else if (cmd inside {[CMD_REAR_OFF:CMD_REAR_FLASH]}) begin
      d.lamp = LAMP_REAR;
      d.act  = 2'(cmd - CMD_REAR_OFF);
    end else if (cmd inside {[CMD_LEFT_OFF:CMD_LEFT_FLASH]}) begin
      d.lamp = LAMP_LEFT;
      d.act  = 2'(cmd - CMD_LEFT_OFF);
    end else if (cmd inside {[CMD_RIGHT_OFF:CMD_RIGHT_FLASH]}) begin
      d.lamp = LAMP_RIGHT;
      d.act  = 2'(cmd - CMD_RIGHT_OFF);
    end
    return d;
  endfunction

  function automatic logic [1:0] wide_code(input logic lit, input logic [PER_W-1:0] per);
    logic [1:0] c;
    if (per == '0) begin
      c = lit ? ST_ON : ST_OFF;
    end else begin
      c = lit ? ST_FLASH_LIT : ST_OFF;
    end
    return c;
  endfunction

endpackage

### rtl/core/lsfc_channels.sv
// ----------------------------------------------------------------------------
// lsfc channels
// Valid/ready channel interfaces for command/tick items and result items.
// ----------------------------------------------------------------------------
interface lsfc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  command;
  logic [15:0] flash_period;

  modport source (output valid, kind, command, flash_period, input ready);
  modport sink   (input valid, kind, command, flash_period, output ready);
endinterface

interface lsfc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [15:0] switch_word;
  logic [15:0] status_wide;
  logic [7:0]  status_narrow;
  logic        brake_conflict;

  modport source (output valid, frame_valid, switch_word, status_wide, status_narrow,
                  brake_conflict, input ready);
  modport sink   (input valid, frame_valid, switch_word, status_wide, status_narrow,
                  brake_conflict, output ready);
endinterface

### rtl/core/lsfc_mod_unit.sv
// ----------------------------------------------------------------------------
// lsfc_mod_unit
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module lsfc_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  lsfc_pkg::mod_req_t req,
  output lsfc_pkg::mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(lsfc_pkg::CNT_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [lsfc_pkg::PER_W-1:0]  rem_r, rem_nxt;
  logic [lsfc_pkg::CNT_W-1:0]  shf_r, shf_nxt;
  logic [lsfc_pkg::PER_W-1:0]  div_r, div_nxt;
  logic [lsfc_pkg::PER_W:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    div_nxt  = div_r;
    trial    = {rem_r, shf_r[lsfc_pkg::CNT_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      shf_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      shf_nxt = {shf_r[lsfc_pkg::CNT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = lsfc_pkg::PER_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[lsfc_pkg::PER_W-1:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(lsfc_pkg::CNT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

### rtl/core/lamp_switch_flash_controller.sv
// ----------------------------------------------------------------------------
// lamp_switch_flash_controller
// Brake/motor/lamp switch state with timed lamp flashing and switch word output.
// ----------------------------------------------------------------------------
// A command item, or a tick while the count or the send period is zero, goes
// straight to the finish state. Any other tick runs a 32-step remainder of the
// count by the send period and waits for its result. On a send-period boundary
// the sequencer then visits each of the four lamp slots in turn and runs one
// more remainder for each lamp with a nonzero flash period. Every item waits in
// the finish state until the output register is free. All remainders share one
// bit-serial modulo unit, which sets the rate. A finished result sits in the
// output register while the next item is accepted.
module lamp_switch_flash_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata,
  lsfc_in_if.sink           in_ch,
  lsfc_out_if.source        out_ch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEND   = 3'd1;
  localparam logic [2:0] S_LAMP   = 3'd2;
  localparam logic [2:0] S_LWAIT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam int NL = lsfc_pkg::NUM_LAMPS;
  localparam int LW = lsfc_pkg::LAMP_W;
  localparam int PW = lsfc_pkg::PER_W;

  logic [2:0]                  state_r, state_nxt;
  logic [PW-1:0]               send_period_r;
  logic                        upper_supply_r;
  logic [lsfc_pkg::CNT_W-1:0]  tick_count_r, tick_count_nxt;
  logic                        brake_r, brake_nxt;
  logic                        motor_r, motor_nxt;
  logic [NL-1:0]               lit_r, lit_nxt;
  logic [PW-1:0]               period_r [NL];
  logic [PW-1:0]               period_nxt [NL];
  logic [LW-1:0]               idx_r, idx_nxt;
  logic                        tick_r, tick_nxt;
  logic                        frame_r, frame_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        o_frame_r;
  logic [15:0]                 o_word_r, o_wide_r;
  logic [7:0]                  o_narrow_r;
  logic                        o_conflict_r;
  logic                        out_load;

  lsfc_pkg::mod_req_t          mod_req;
  lsfc_pkg::mod_rsp_t          mod_rsp;
  lsfc_pkg::cmd_dec_t          dec;
  logic                        accept;
  logic [15:0]                 word_c, wide_c;
  logic [7:0]                  narrow_c;

  lsfc_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign dec         = lsfc_pkg::decode_cmd(in_ch.command);

  always_comb begin
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    brake_nxt      = brake_r;
    motor_nxt      = motor_r;
    lit_nxt        = lit_r;
    period_nxt     = period_r;
    idx_nxt        = idx_r;
    tick_nxt       = tick_r;
    frame_nxt      = frame_r;
    out_load       = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = tick_count_r;
    mod_req.divisor  = period_r[idx_r];

    case (state_r)
      S_IDLE: begin
        mod_req.divisor = send_period_r;
        if (accept) begin
          frame_nxt = 1'b0;
          idx_nxt   = '0;
          tick_nxt  = (in_ch.kind == lsfc_pkg::KIND_TICK);
          state_nxt = S_FINISH;
          if (in_ch.kind == lsfc_pkg::KIND_TICK) begin
            if (send_period_r != '0 && tick_count_r != '0) begin
              mod_req.start = 1'b1;
              state_nxt     = S_SEND;
            end
          end else begin
            case (in_ch.command)
              lsfc_pkg::CMD_BRAKE_OFF: brake_nxt = 1'b0;
              lsfc_pkg::CMD_BRAKE_ON:  brake_nxt = 1'b1;
              lsfc_pkg::CMD_MOTOR_OFF: motor_nxt = 1'b0;
              lsfc_pkg::CMD_MOTOR_ON:  motor_nxt = 1'b1;
              default: begin
                if (dec.act == lsfc_pkg::ACT_FLASH) begin
                  period_nxt[dec.lamp] = in_ch.flash_period;
                end else begin
                  lit_nxt[dec.lamp]    = (dec.act == lsfc_pkg::ACT_ON);
                  period_nxt[dec.lamp] = '0;
                end
              end
            endcase
          end
        end
      end
      S_SEND: begin
        if (mod_rsp.done) begin
          if (mod_rsp.zero) begin
            frame_nxt = 1'b1;
            state_nxt = S_LAMP;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_LAMP: begin
        if (period_r[idx_r] != '0) begin
          mod_req.start = 1'b1;
          state_nxt     = S_LWAIT;
        end else if (idx_r == LW'(NL - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LWAIT: begin
        if (mod_rsp.done) begin
          if (mod_rsp.zero) begin
            lit_nxt[idx_r] = ~lit_r[idx_r];
          end
          if (idx_r == LW'(NL - 1)) begin
            state_nxt = S_FINISH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_LAMP;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (tick_r) begin
            tick_count_nxt = (tick_count_r == lsfc_pkg::TICK_LAST) ? '0
                           : tick_count_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result words from the state after the item
  always_comb begin
    word_c = '0;
    if (frame_r) begin
      word_c = (lit_r[lsfc_pkg::LAMP_LEFT]  ? lsfc_pkg::SW_LEFT  : 16'h0)
             | (lit_r[lsfc_pkg::LAMP_RIGHT] ? lsfc_pkg::SW_RIGHT : 16'h0)
             | (brake_r                     ? lsfc_pkg::SW_BRAKE : 16'h0)
             | (lit_r[lsfc_pkg::LAMP_HEAD]  ? lsfc_pkg::SW_HEAD  : 16'h0)
             | (upper_supply_r              ? lsfc_pkg::SW_UPPER : 16'h0);
    end
    wide_c = {2'b00,
              lsfc_pkg::wide_code(lit_r[lsfc_pkg::LAMP_LEFT], period_r[lsfc_pkg::LAMP_LEFT]),
              lsfc_pkg::wide_code(lit_r[lsfc_pkg::LAMP_RIGHT], period_r[lsfc_pkg::LAMP_RIGHT]),
              3'b000, motor_r, 1'b0, upper_supply_r, 1'b0, brake_r,
              lsfc_pkg::wide_code(lit_r[lsfc_pkg::LAMP_HEAD], period_r[lsfc_pkg::LAMP_HEAD])};
    narrow_c = {1'b0, lit_r[lsfc_pkg::LAMP_LEFT], lit_r[lsfc_pkg::LAMP_RIGHT], 1'b0,
                motor_r, upper_supply_r, brake_r, lit_r[lsfc_pkg::LAMP_HEAD]};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      send_period_r  <= lsfc_pkg::SEND_PERIOD_RST;
      upper_supply_r <= lsfc_pkg::UPPER_SUPPLY_RST;
      tick_count_r   <= '0;
      brake_r        <= 1'b1;
      motor_r        <= 1'b0;
      lit_r          <= '0;
      for (int i = 0; i < NL; i++) begin
        period_r[i] <= '0;
      end
      idx_r          <= '0;
      tick_r         <= 1'b0;
      frame_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      brake_r      <= brake_nxt;
      motor_r      <= motor_nxt;
      lit_r        <= lit_nxt;
      period_r     <= period_nxt;
      idx_r        <= idx_nxt;
      tick_r       <= tick_nxt;
      frame_r      <= frame_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lsfc_pkg::CFG_SEND_PERIOD:  send_period_r  <= cfg_wdata;
          lsfc_pkg::CFG_UPPER_SUPPLY: upper_supply_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    if (out_load) begin
      o_frame_r    <= frame_r;
      o_word_r     <= word_c;
      o_wide_r     <= wide_c;
      o_narrow_r   <= narrow_c;
      o_conflict_r <= motor_r & brake_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_valid    = o_frame_r;
  assign out_ch.switch_word    = o_word_r;
  assign out_ch.status_wide    = o_wide_r;
  assign out_ch.status_narrow  = o_narrow_r;
  assign out_ch.brake_conflict = o_conflict_r;

  // counter never goes past the wrap value
  a_tick_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    tick_count_r != 32'hFFFF_FFFE)
    else $error("tick counter past wrap value");

  // remainder unit never started with a zero divisor or while busy
  a_mod_start: assert property (@(posedge clk) disable iff (!rst_n)
    mod_req.start |-> (mod_req.divisor != '0 && !mod_rsp.busy))
    else $error("bad remainder start");

  // remainder results only arrive while the sequencer waits for one
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_SEND || state_r == S_LWAIT))
    else $error("unexpected remainder result");

  // a beat without a frame carries a zero switch word
  a_no_frame_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_frame_r) |-> (o_word_r == '0))
    else $error("switch word without frame");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lamp switch flash controller: drives command and
// tick beats with bursty timing, predicts switch word and status per beat,
// and compares each result beat field by field under random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lsfc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] switch_word;
    logic [15:0] status_wide;
    logic [7:0]  status_narrow;
    logic        brake_conflict;
  } switch_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        rx_ready = 1'b0;
  logic [9:0]  stall_cycle = '0;
  int          cycle_count = 0;
  int          err_count = 0;
  int          burst_left = 0;

  // predicted switch state
  logic [CNT_W-1:0] sw_ticks;
  logic             sw_brake;
  logic             sw_motor;
  logic             sw_lit   [NUM_LAMPS];
  logic [PER_W-1:0] sw_flash [NUM_LAMPS];
  logic [PER_W-1:0] sw_send;
  logic             sw_upper;

  switch_result_t expected_switch_q[$];

  lsfc_in_if  in_ch ();
  lsfc_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  lamp_switch_flash_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL lamp_switch_flash_controller");
      $finish;
    end
  end

  // receiver: free-running, light random, periodic long stalls, coin flip
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 10'd1;
    case (stall_cycle[9:8])
      2'd0:    rx_ready <= 1'b1;
      2'd1:    rx_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    rx_ready <= (stall_cycle[3:0] > 4'd5);
      default: rx_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic logic [1:0] lamp_status(input int lamp);
    logic [1:0] code;
    if (!sw_lit[lamp]) begin
      code = ST_OFF;
    end else if (sw_flash[lamp] != '0) begin
      code = ST_FLASH_LIT;
    end else begin
      code = ST_ON;
    end
    return code;
  endfunction

  function automatic switch_result_t predict_switch_state(input logic kind,
                                                          input logic [3:0] command,
                                                          input logic [15:0] period);
    switch_result_t r;
    int lamp;
    logic [1:0] act;
    r = '0;
    if (kind == KIND_CMD) begin
      case (command)
        CMD_BRAKE_OFF: sw_brake = 1'b0;
        CMD_BRAKE_ON:  sw_brake = 1'b1;
        CMD_MOTOR_OFF: sw_motor = 1'b0;
        CMD_MOTOR_ON:  sw_motor = 1'b1;
        default: begin
          // three actions per lamp, lamps in slot order from head
          lamp = (command - CMD_HEAD_OFF) / 3;
          act  = 2'((command - CMD_HEAD_OFF) % 3);
          if (act == ACT_FLASH) begin
            sw_flash[lamp] = period;
          end else begin
            sw_lit[lamp]   = (act == ACT_ON);
            sw_flash[lamp] = '0;
          end
        end
      endcase
    end else begin
      if (sw_send != '0 && sw_ticks != '0 && (sw_ticks % sw_send) == '0) begin
        for (int l = 0; l < NUM_LAMPS; l++) begin
          if (sw_flash[l] != '0 && (sw_ticks % sw_flash[l]) == '0) sw_lit[l] = ~sw_lit[l];
        end
        r.frame_valid = 1'b1;
        r.switch_word = (sw_lit[LAMP_LEFT]  ? SW_LEFT  : 16'h0)
                      | (sw_lit[LAMP_RIGHT] ? SW_RIGHT : 16'h0)
                      | (sw_brake           ? SW_BRAKE : 16'h0)
                      | (sw_lit[LAMP_HEAD]  ? SW_HEAD  : 16'h0)
                      | (sw_upper           ? SW_UPPER : 16'h0);
      end
      sw_ticks = (sw_ticks == TICK_LAST) ? '0 : sw_ticks + 1;
    end
    r.status_wide   = {2'b00, lamp_status(LAMP_LEFT), lamp_status(LAMP_RIGHT), 3'b000,
                       sw_motor, 1'b0, sw_upper, 1'b0, sw_brake, lamp_status(LAMP_HEAD)};
    r.status_narrow = {1'b0, sw_lit[LAMP_LEFT], sw_lit[LAMP_RIGHT], 1'b0,
                       sw_motor, sw_upper, sw_brake, sw_lit[LAMP_HEAD]};
    r.brake_conflict = sw_motor & sw_brake;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_beat
    switch_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && rx_ready) begin
      if (expected_switch_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_ch.status_wide, '0);
      end else begin
        want = expected_switch_q.pop_front();
        if (out_ch.frame_valid !== want.frame_valid)
          report_mismatch("frame_valid", 16'(out_ch.frame_valid), 16'(want.frame_valid));
        if (out_ch.switch_word !== want.switch_word)
          report_mismatch("switch_word", out_ch.switch_word, want.switch_word);
        if (out_ch.status_wide !== want.status_wide)
          report_mismatch("status_wide", out_ch.status_wide, want.status_wide);
        if (out_ch.status_narrow !== want.status_narrow)
          report_mismatch("status_narrow", 16'(out_ch.status_narrow), 16'(want.status_narrow));
        if (out_ch.brake_conflict !== want.brake_conflict)
          report_mismatch("brake_conflict", 16'(out_ch.brake_conflict),
                          16'(want.brake_conflict));
      end
    end
  end

  // one beat; the sender may idle between bursts of random length
  task automatic send_item(input logic kind, input logic [3:0] command,
                           input logic [15:0] period);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.command      <= command;
    in_ch.flash_period <= period;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_switch_q.push_back(predict_switch_state(kind, command, period));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_switch_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic index, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == CFG_SEND_PERIOD) begin
      sw_send = value;
    end else begin
      sw_upper = value[0];
    end
  endtask

  task automatic send_random_item();
    logic [15:0] period;
    case ($urandom_range(0, 9))
      0:       period = '0;
      1:       period = 16'hFFFF;
      2:       period = 16'($urandom);
      3:       period = 16'(sw_send * $urandom_range(1, 3));
      default: period = 16'($urandom_range(1, 6));
    endcase
    // tick beats carry junk in the command fields
    if ($urandom_range(0, 99) < 45) begin
      send_item(KIND_TICK, 4'($urandom), period);
    end else begin
      send_item(KIND_CMD, 4'($urandom_range(0, 15)), period);
    end
  endtask

  task automatic run_traffic_phase(input logic [15:0] send_period, input int items);
    wait_for_results();
    write_config(CFG_SEND_PERIOD, send_period);
    write_config(CFG_UPPER_SUPPLY, {15'($urandom), 1'($urandom)});
    repeat (items) send_random_item();
  endtask

  task automatic test_all_commands();
    for (int c = 0; c < 16; c++) begin
      send_item(KIND_CMD, 4'(c), (c % 2 == 0) ? 16'hFFFF : 16'h5555);
    end
    // count zero never emits; second tick is off the reset send period
    send_item(KIND_TICK, 4'hF, 16'hFFFF);
    send_item(KIND_TICK, 4'h0, 16'h0000);
  endtask

  task automatic test_zero_send_period();
    wait_for_results();
    write_config(CFG_SEND_PERIOD, 16'h0000);
    write_config(CFG_UPPER_SUPPLY, 16'h0000);
    send_item(KIND_TICK, 4'h0, 16'h0000);
    send_item(KIND_TICK, 4'h0, 16'h0000);
  endtask

  task automatic test_flash_toggle();
    wait_for_results();
    write_config(CFG_SEND_PERIOD, 16'd1);
    write_config(CFG_UPPER_SUPPLY, 16'hFFFF);
    send_item(KIND_CMD, CMD_LEFT_FLASH, 16'd1);
    send_item(KIND_CMD, CMD_RIGHT_FLASH, 16'd2);
    send_item(KIND_CMD, CMD_MOTOR_ON, 16'd0);
    send_item(KIND_CMD, CMD_BRAKE_ON, 16'd0);
    repeat (3) send_item(KIND_TICK, 4'h0, 16'h0000);
    // flash with zero period freezes the lamp where it is
    send_item(KIND_CMD, CMD_LEFT_FLASH, 16'd0);
    send_item(KIND_TICK, 4'h0, 16'h0000);
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(16'd1, 80);
    run_traffic_phase(16'd2, 80);
    run_traffic_phase(16'd3, 80);
    run_traffic_phase(16'd4, 80);
    run_traffic_phase(16'd5, 80);
    run_traffic_phase(16'($urandom_range(6, 12)), 80);
    run_traffic_phase(16'hFFFF, 30);
    run_traffic_phase(16'($urandom_range(1, 4)), 80);
    // period equal to the current count: the very next tick emits
    wait_for_results();
    run_traffic_phase((sw_ticks[15:0] == '0) ? 16'd1 : sw_ticks[15:0], 80);
    run_traffic_phase(16'd2, 80);
    run_traffic_phase(16'd3, 80);
    run_traffic_phase(16'd1, 80);
  endtask

  initial begin
    sw_ticks = '0;
    sw_brake = 1'b1;
    sw_motor = 1'b0;
    for (int l = 0; l < NUM_LAMPS; l++) begin
      sw_lit[l]   = 1'b0;
      sw_flash[l] = '0;
    end
    sw_send  = SEND_PERIOD_RST;
    sw_upper = UPPER_SUPPLY_RST;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SEND_PERIOD;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_CMD;
    in_ch.command      <= CMD_BRAKE_OFF;
    in_ch.flash_period <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_all_commands();
    test_zero_send_period();
    test_flash_toggle();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_switch_q.size() == 0) begin
      $display("PASS lamp_switch_flash_controller");
    end else begin
      $display("FAIL lamp_switch_flash_controller");
    end
    $finish;
  end

endmodule
